### hw/rtl/multichannel_add_with_slewed_offset_assert.svh
// Assertion macros shared by the RTL; they expect clk and arst_n in scope.
`ifndef MULTICHANNEL_ADD_WITH_SLEWED_OFFSET_ASSERT_SVH
`define MULTICHANNEL_ADD_WITH_SLEWED_OFFSET_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define MCASO_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define MCASO_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/mcaso_pkg.sv
package mcaso_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int CH_W        = 3;
	localparam int COEFF_W     = 17;
	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 32;

	localparam logic [COEFF_W-1:0] COEFF_ONE = 17'h10000;

	localparam logic [1:0] MODE_CONST = 2'd0;
	localparam logic [1:0] MODE_MONO  = 2'd1;
	localparam logic [1:0] MODE_PERCH = 2'd2;

	localparam logic [2:0] REG_MODE   = 3'd0;
	localparam logic [2:0] REG_SLEW   = 3'd1;
	localparam logic [2:0] REG_COEFF  = 3'd2;
	localparam logic [2:0] REG_CONSTB = 3'd3;
	localparam logic [2:0] REG_ACTIVE = 3'd4;

	typedef struct packed {
		logic [CH_W-1:0]               channel;
		logic signed [SAMPLE_BITS-1:0] sample_a;
		logic signed [SAMPLE_BITS-1:0] sample_b;
	} in_item_t;

	typedef struct packed {
		logic [CH_W-1:0]               out_channel;
		logic signed [SAMPLE_BITS-1:0] sum_sample;
		logic                          clipped;
	} out_item_t;

	typedef struct packed {
		logic [1:0]                    mode;
		logic                          slew_enable;
		logic [COEFF_W-1:0]            coeff;
		logic signed [SAMPLE_BITS-1:0] constant_b;
		logic [3:0]                    active_channels;
		logic                          clear_started;
	} cfg_t;

endpackage

### hw/rtl/mcaso_regs.sv
module mcaso_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mcaso_pkg::ADDR_W-1:0] paddr,
	input  logic [mcaso_pkg::DATA_W-1:0] pwdata,
	output logic [mcaso_pkg::DATA_W-1:0] prdata,
	output logic                         pready,
	output mcaso_pkg::cfg_t              cfg
);

	logic [1:0]                               mode_q;
	logic                                     slew_q;
	logic [mcaso_pkg::COEFF_W-1:0]            coeff_q;
	logic signed [mcaso_pkg::SAMPLE_BITS-1:0] constb_q;
	logic [3:0]                               active_q;
	logic [2:0]                               idx;
	logic                                     wr;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr     = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= mcaso_pkg::MODE_MONO;
			slew_q   <= 1'b0;
			coeff_q  <= mcaso_pkg::COEFF_ONE;
			constb_q <= 16'sh7FFF;
			active_q <= 4'd2;
		end else if (wr) begin
			unique case (idx)
				mcaso_pkg::REG_MODE:   mode_q   <= pwdata[1:0];
				mcaso_pkg::REG_SLEW:   slew_q   <= pwdata[0];
				mcaso_pkg::REG_COEFF:  coeff_q  <= pwdata[16:0];
				mcaso_pkg::REG_CONSTB: constb_q <= $signed(pwdata[15:0]);
				mcaso_pkg::REG_ACTIVE: active_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			mcaso_pkg::REG_MODE:   prdata = 32'(mode_q);
			mcaso_pkg::REG_SLEW:   prdata = 32'(slew_q);
			mcaso_pkg::REG_COEFF:  prdata = 32'(coeff_q);
			mcaso_pkg::REG_CONSTB: prdata = {16'b0, constb_q};
			mcaso_pkg::REG_ACTIVE: prdata = 32'(active_q);
			default:               prdata = '0;
		endcase
	end

	always_comb begin
		cfg.mode            = mode_q;
		cfg.slew_enable     = slew_q;
		cfg.coeff           = coeff_q;
		cfg.constant_b      = constb_q;
		cfg.active_channels = active_q;
		cfg.clear_started   = wr && (idx == mcaso_pkg::REG_ACTIVE);
	end

endmodule

### hw/rtl/multichannel_add_with_slewed_offset.sv
// Adds sample A to an operand B that may pass through a one-pole slew smoother, per channel
// or shared per frame, and saturates the sum to 16 bits with a clip flag. Throughput is one
// transfer per cycle while out_stall does not hold the result. The smoother multiply, its
// round-and-add and the final saturating add all sit between the input register and the
// result register, and the smoother state is updated as each item moves to the result
// register, so the next item sees any smoother level that the one before it updated.
module multichannel_add_with_slewed_offset #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mcaso_pkg::ADDR_W-1:0] paddr,
	input  logic [mcaso_pkg::DATA_W-1:0] pwdata,
	output logic [mcaso_pkg::DATA_W-1:0] prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  mcaso_pkg::in_item_t          in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output mcaso_pkg::out_item_t         out_data
);

	`include "multichannel_add_with_slewed_offset_assert.svh"

	localparam int DEPTH = (MAX_CHANNELS < (1 << mcaso_pkg::CH_W)) ? MAX_CHANNELS
		: (1 << mcaso_pkg::CH_W);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	mcaso_pkg::cfg_t cfg;

	mcaso_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	function automatic logic signed [15:0] smooth(
		input logic signed [15:0] level,
		input logic               started,
		input logic signed [15:0] target,
		input logic               slew,
		input logic [16:0]        coeff
	);
		logic [16:0]        c;
		logic signed [16:0] diff;
		logic signed [34:0] prod;
		logic signed [34:0] q;
		logic signed [18:0] step;
		logic signed [18:0] r;
		c    = (coeff > mcaso_pkg::COEFF_ONE) ? mcaso_pkg::COEFF_ONE : coeff;
		diff = $signed({target[15], target}) - $signed({level[15], level});
		prod = $signed({1'b0, c}) * diff;
		q    = prod + 35'sd32768;
		step = $signed(q[34:16]);
		r    = $signed({{3{level[15]}}, level}) + step;
		if (!started || !slew) begin
			return target;
		end else if (r[18:15] == 4'b0000 || r[18:15] == 4'b1111) begin
			return r[15:0];
		end else begin
			return r[18] ? 16'sh8000 : 16'sh7FFF;
		end
	endfunction

	logic                       valid_s1;
	mcaso_pkg::in_item_t        item_s1;
	logic                       out_valid_s2;
	mcaso_pkg::out_item_t       out_item_s2;
	logic                       out_free;
	logic                       commit;

	logic signed [15:0]         shared_level_q;
	logic                       shared_started_q;
	logic signed [15:0]         chan_level_q [DEPTH];
	logic [DEPTH-1:0]           chan_started_q;

	logic [IDX_W-1:0]           idx;
	logic                       in_range;
	logic                       per_ch;
	logic signed [15:0]         target;
	logic signed [15:0]         shared_next;
	logic signed [15:0]         chan_next;
	logic signed [15:0]         b;
	logic signed [16:0]         sum;
	mcaso_pkg::out_item_t       result;

	assign out_free  = !out_valid_s2 || !out_stall;
	assign commit    = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign out_valid = out_valid_s2;
	assign out_data  = out_item_s2;

	assign idx      = item_s1.channel[IDX_W-1:0];
	assign in_range = int'(item_s1.channel) < DEPTH;
	assign per_ch   = cfg.mode[1];

	always_comb begin
		target      = (cfg.mode == mcaso_pkg::MODE_CONST) ? cfg.constant_b : item_s1.sample_b;
		shared_next = smooth(shared_level_q, shared_started_q, target, cfg.slew_enable,
			cfg.coeff);
		chan_next   = smooth(chan_level_q[idx], chan_started_q[idx], target, cfg.slew_enable,
			cfg.coeff);
		if (per_ch) begin
			b = in_range ? chan_next : target;
		end else if (item_s1.channel == '0) begin
			b = shared_next;
		end else begin
			b = shared_started_q ? shared_level_q : target;
		end
		sum = $signed({item_s1.sample_a[15], item_s1.sample_a}) + $signed({b[15], b});
		result.out_channel = item_s1.channel;
		if (sum[16] != sum[15]) begin
			result.sum_sample = sum[16] ? 16'sh8000 : 16'sh7FFF;
			result.clipped    = 1'b1;
		end else begin
			result.sum_sample = sum[15:0];
			result.clipped    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (out_free) begin
				out_valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
		if (commit) begin
			out_item_s2 <= result;
		end
	end

	// smoother state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shared_started_q <= 1'b0;
			chan_started_q   <= '0;
		end else if (cfg.clear_started) begin
			chan_started_q <= '0;
		end else if (commit) begin
			if (per_ch && in_range) begin
				chan_started_q[idx] <= 1'b1;
			end else if (!per_ch && item_s1.channel == '0) begin
				shared_started_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			if (per_ch && in_range) begin
				chan_level_q[idx] <= chan_next;
			end else if (!per_ch && item_s1.channel == '0) begin
				shared_level_q <= shared_next;
			end
		end
	end

	`MCASO_ASSERT_NOW(a_stall_needs_item, in_stall, valid_s1, "stall without a held item")
	`MCASO_ASSERT_NEXT(a_shared_starts, commit && !per_ch && item_s1.channel == '0,
		shared_started_q, "shared smoother not started after channel 0 transfer")
	`MCASO_ASSERT_NOW(a_clip_at_rail, out_valid_s2 && out_item_s2.clipped,
		out_item_s2.sum_sample == 16'sh7FFF || out_item_s2.sum_sample == 16'sh8000,
		"clip flag set on an unsaturated sum")
	`MCASO_ASSERT_NOW(a_result_from_commit, $rose(out_valid_s2), $past(commit),
		"result valid without a committed item")

endmodule
